@@ sv/cpf_pkg.sv @@
// Package with the shared types, constants and id tables of the command packet framer.
package cpf_pkg;

    typedef logic [7:0] t_byte;

    localparam int unsigned MAX_BURST = 7;
    localparam int unsigned HEADER_LEN = 6;
    localparam t_byte FRAME_PREFIX = 8'hFF;

    typedef logic [2:0] t_count;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  msg_type;
        t_byte       seq_num;
        t_byte       payload_len;
        t_byte       data_byte;
    } t_in_word;

    typedef struct packed {
        t_count                      count;
        logic [MAX_BURST-1:0][7:0]   bytes;
        logic [MAX_BURST-1:0]        lasts;
    } t_burst;

    // Device ids by message type; unknown types map to 0xFF.
    localparam t_byte DEV_ID [32] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd1,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

    // Command ids by message type; unknown types map to 0xFF.
    localparam t_byte CMD_ID [32] = '{
        8'd0, 8'd2, 8'd16, 8'd17, 8'd34, 8'd48, 8'd64,
        8'd4,
        8'd1, 8'd2, 8'd3, 8'd32, 8'd33, 8'd48, 8'd49, 8'd51, 8'd64,
        8'd80, 8'd81, 8'd82, 8'd85, 8'd17, 8'd51, 8'd51, 8'd33,
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
    };

endpackage

@@ sv/cpf_if.sv @@
// Valid/ready channel interfaces for the input words and the output bytes of the framer.
interface cpf_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [4:0] msg_type;
    logic [7:0] seq_num;
    logic [7:0] payload_len;
    logic [7:0] data_byte;

    modport source (output valid, cmd, msg_type, seq_num, payload_len, data_byte,
                    input ready);
    modport sink (input valid, cmd, msg_type, seq_num, payload_len, data_byte,
                  output ready);
endinterface

interface cpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

@@ sv/cpf_framer.sv @@
// Packet state and the logic that turns one input word into a burst of output bytes.
module cpf_framer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cpf_pkg::t_in_word i_word,
    output cpf_pkg::t_burst   o_burst
);
    import cpf_pkg::*;

    t_byte r_sum;
    t_byte r_left;
    logic  r_in_packet;
    t_byte n_sum;
    t_byte n_left;
    logic  n_in_packet;

    t_byte dev;
    t_byte cid;
    t_byte lenb;
    t_byte hsum;
    t_byte dsum;
    t_byte dleft;

    always_comb begin
        dev   = DEV_ID[i_word.msg_type];
        cid   = CMD_ID[i_word.msg_type];
        lenb  = i_word.payload_len + 8'd1;
        hsum  = dev + cid + i_word.seq_num + lenb;
        dsum  = r_sum + i_word.data_byte;
        dleft = r_left - 8'd1;

        n_sum       = r_sum;
        n_left      = r_left;
        n_in_packet = r_in_packet;
        o_burst     = '0;

        if (i_word.cmd == CMD_START) begin
            o_burst.bytes[0] = FRAME_PREFIX;
            o_burst.bytes[1] = FRAME_PREFIX;
            o_burst.bytes[2] = dev;
            o_burst.bytes[3] = cid;
            o_burst.bytes[4] = i_word.seq_num;
            o_burst.bytes[5] = lenb;
            o_burst.bytes[6] = ~hsum;
            n_sum  = hsum;
            n_left = i_word.payload_len;
            if (i_word.payload_len == 8'd0) begin
                o_burst.count    = t_count'(MAX_BURST);
                o_burst.lasts[6] = 1'b1;
                n_in_packet      = 1'b0;
            end else begin
                o_burst.count = t_count'(HEADER_LEN);
                n_in_packet   = 1'b1;
            end
        end else if (r_in_packet && (r_left != 8'd0)) begin
            o_burst.bytes[0] = i_word.data_byte;
            n_sum  = dsum;
            n_left = dleft;
            if (dleft == 8'd0) begin
                o_burst.bytes[1] = ~dsum;
                o_burst.lasts[1] = 1'b1;
                o_burst.count    = 3'd2;
                n_in_packet      = 1'b0;
            end else begin
                o_burst.count = 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_left      <= '0;
            r_in_packet <= 1'b0;
        end else if (i_load) begin
            r_sum       <= n_sum;
            r_left      <= n_left;
            r_in_packet <= n_in_packet;
        end
    end

endmodule

@@ sv/cpf_emitter.sv @@
// Burst register that sends the bytes of one word out one per cycle while the receiver is ready.
module cpf_emitter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  cpf_pkg::t_burst i_burst,
    input  logic            i_ready,
    output logic            o_can_load,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_last
);
    import cpf_pkg::*;

    logic [MAX_BURST-1:0][7:0] r_bytes;
    logic [MAX_BURST-1:0]      r_lasts;
    t_count                    r_cnt;
    logic                      pop;

    assign pop        = (r_cnt != '0) && i_ready;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == 3'd1) && i_ready);
    assign o_valid    = (r_cnt != '0);
    assign o_byte     = r_bytes[0];
    assign o_last     = r_lasts[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_lasts <= i_burst.lasts;
        end else if (pop) begin
            r_bytes <= r_bytes >> 8;
            r_lasts <= r_lasts >> 1;
        end
    end

endmodule

@@ sv/command_packet_framer_core.sv @@
// Top level of the command packet framer.
//
// The input channel takes one word per handshake: a start word (cmd 0) with message type,
// sequence number and payload length, or a payload word (cmd 1) with one data byte.
// The output channel gives the framed bytes of each word, with last set on the checksum.
// A start word yields six header bytes, plus the checksum when the length is zero.
// A payload word inside a packet yields its byte, and the checksum after the final one.
// Payload words outside a packet are dropped and yield nothing.
// The first byte of an accepted word appears in the cycle after it is accepted.
// Input is ready when the burst register is empty or sends its final byte this cycle,
// so payload words stream at one per cycle while the receiver is ready; a start word
// and the closing payload word hold the input until their final byte is sent, as the
// output register sends one byte per cycle.
// Reset clears the packet state and empties the burst register.
// When the receiver stalls, the current byte holds and input stops once the burst waits.
module command_packet_framer_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cpf_in_if.sink    i_in,
    cpf_out_if.source o_out
);
    import cpf_pkg::*;

    t_in_word word;
    t_burst   burst;
    logic     can_load;
    logic     load;

    assign word.cmd         = i_in.cmd;
    assign word.msg_type    = i_in.msg_type;
    assign word.seq_num     = i_in.seq_num;
    assign word.payload_len = i_in.payload_len;
    assign word.data_byte   = i_in.data_byte;

    assign i_in.ready = can_load;
    assign load       = i_in.valid && can_load;

    cpf_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_word  (word),
        .o_burst (burst)
    );

    cpf_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_burst    (burst),
        .i_ready    (o_out.ready),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .o_byte     (o_out.out_byte),
        .o_last     (o_out.last)
    );

endmodule

@@ sv/cpf_checker.sv @@
// Port-level assertions for the command packet framer and their bind to the top level.
module cpf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_cmd,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    import cpf_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_start_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_START) |=>
            i_out_valid && (i_out_byte == FRAME_PREFIX) && !i_out_last)
        else $error("start word did not open with the frame prefix");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input ready while a stalled burst waits");

endmodule

bind command_packet_framer_core cpf_checker u_cpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);
